### rtl/ctte_pkg.sv
// shared types, constants and small tables for the ctime text to epoch block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ctte_pkg;

  localparam int FIELD_COUNT = 6;
  localparam int MONTH_AT    = 4;
  localparam int ZONE_LENGTH = 30;
  localparam int MAX_DIGITS  = 5;
  localparam int MAG_W       = 17;
  localparam int SVAL_W      = 18;
  localparam int EPOCH_W     = 43;
  localparam int OFFSET_W    = 12;

  // field slots
  localparam int F_DAY  = 0;
  localparam int F_HOUR = 1;
  localparam int F_MIN  = 2;
  localparam int F_SEC  = 3;
  localparam int F_YEAR = 4;
  localparam int F_ZONE = 5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // divide by 25 as multiply by reciprocal, one correction step
  localparam int DIV25_MUL   = 5243;
  localparam int DIV25_SHIFT = 17;
  localparam int DIV_BIAS_Q  = 2000;
  localparam int DIV_BIAS_X  = 50000;
  // days from 0000-03-01 to 1970-01-01, plus one for the day-of-month base
  localparam int EPOCH_DAY0  = 719469;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic             neg;
    logic             over;
    logic [2:0]       dig;
    logic [MAG_W-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } field_t;

  typedef struct packed {
    logic                        ok;
    logic                        zone;
    logic [3:0]                  month;
    field_t [FIELD_COUNT-1:0]    fields;
  } rec_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic                      time_valid;
    logic                      zone_suffix_used;
  } out_item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_Y100_MUL,
    B_Y100_FIX,
    B_ZONE_MUL,
    B_ZONE_FIX,
    B_DAYS_A,
    B_DAYS_B,
    B_DAYS_C,
    B_SEC_MUL,
    B_SEC_HOUR,
    B_SEC_MIN,
    B_SEC_OFF,
    B_SEC_ZONE,
    B_DONE
  } back_state_t;

  function automatic logic [4:0] field_start(input int unsigned idx);
    logic [4:0] s;
    case (idx)
      0:       s = 5'd8;
      1:       s = 5'd11;
      2:       s = 5'd14;
      3:       s = 5'd17;
      4:       s = 5'd20;
      5:       s = 5'd25;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [23:0] month_word(input logic [3:0] idx);
    logic [23:0] w;
    case (idx)
      4'd0:    w = "Jan";
      4'd1:    w = "Feb";
      4'd2:    w = "Mar";
      4'd3:    w = "Apr";
      4'd4:    w = "May";
      4'd5:    w = "Jun";
      4'd6:    w = "Jul";
      4'd7:    w = "Aug";
      4'd8:    w = "Sep";
      4'd9:    w = "Oct";
      4'd10:   w = "Nov";
      4'd11:   w = "Dec";
      default: w = 24'h0;
    endcase
    return w;
  endfunction

  // days from 1 march to the first of the month, march-based year
  function automatic logic [8:0] month_doy(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [SVAL_W-1:0] field_sv(input field_t f);
    logic signed [SVAL_W-1:0] v;
    v = $signed({1'b0, f.mag});
    return f.neg ? -v : v;
  endfunction

endpackage

`default_nettype wire

### rtl/ctime_text_to_epoch_top.sv
// ctime text to epoch seconds: one character per cycle in, one result per string out
// steps: the back sequencer takes the record when idle, runs 12 arithmetic steps, then
// loads the result register once it is free or being popped
// flow: one character per cycle unless the queue is full; the back takes one record
// at a time; a two-record queue lets short strings arrive back to back for a while
// reset: synchronous; clears parse state, queue, result valid flag and the local offset
`timescale 1ns / 1ps
`default_nettype none

module ctime_text_to_epoch_top import ctte_pkg::*; #(
  parameter int TEXT_BUFFER_LENGTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire in_item_t                   in_item,
  output logic                            empty,
  input  wire logic                       pop,
  output out_item_t                       out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic signed [OFFSET_W-1:0] cfg_data
);

  logic rec_push, q_full, q_valid, q_pop;
  rec_t rec, q_head;

  ctte_front #(
    .TEXT_BUFFER_LENGTH(TEXT_BUFFER_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .q_full   (q_full),
    .full     (full),
    .rec_push (rec_push),
    .rec      (rec)
  );

  ctte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  ctte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  // the front never hands a record to a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !rec_push)
    else $error("record request while queue full");

  // the back only takes a record that is there
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while queue empty");

  // an invalid result always carries zero seconds
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.time_valid) |-> (out_item.epoch_seconds == '0))
    else $error("invalid result with non-zero epoch");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result present after reset");

endmodule

`default_nettype wire

### rtl/ctte_front.sv
// front: one character a cycle unless full; gathers month bytes and field values
// depends on ctte_pkg; hands one record per string to the queue
`timescale 1ns / 1ps
`default_nettype none

module ctte_front import ctte_pkg::*; #(
  parameter int TEXT_BUFFER_LENGTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          full,
  output logic          rec_push,
  output rec_t          rec
);

  localparam int PosW = $clog2(TEXT_BUFFER_LENGTH + 1);
  localparam logic [PosW-1:0] PosCap   = PosW'(TEXT_BUFFER_LENGTH);
  localparam logic [PosW-1:0] ParseEnd = PosW'(TEXT_BUFFER_LENGTH - 1);
  localparam logic [PosW-1:0] ZoneAt   = PosW'(ZONE_LENGTH);
  localparam logic [PosW-1:0] MonthAt  = PosW'(MONTH_AT);

  logic [PosW-1:0] pos, pos_next;
  logic [23:0]     month_text, month_text_next;
  logic            ended, ended_next;
  lane_t           lanes      [FIELD_COUNT];
  lane_t           lanes_next [FIELD_COUNT];

  logic       accept, live, parse;
  logic [7:0] c;
  logic       is_digit, is_space, is_sign;

  assign full     = q_full;
  assign accept   = push & ~q_full;
  assign c        = in_item.text_char;
  assign rec_push = accept & in_item.last_char;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);

  always_comb begin
    logic take;
    logic hit;
    logic [3:0] midx;
    logic [4:0] over_all;
    take = 1'b0;
    hit  = 1'b0;
    midx = 4'd0;

    // a nul ends the text; later characters are not counted
    live       = accept & ~ended & (c != CH_NUL);
    parse      = live & (pos < ParseEnd);
    ended_next = ended | (accept & (c == CH_NUL));

    pos_next = pos;
    if (live && (pos != PosCap)) begin
      pos_next = pos + 1'b1;
    end

    month_text_next = month_text;
    if (parse) begin
      if (pos == MonthAt) begin
        month_text_next[23:16] = c;
      end else if (pos == MonthAt + 1'b1) begin
        month_text_next[15:8] = c;
      end else if (pos == MonthAt + 2'd2) begin
        month_text_next[7:0] = c;
      end
    end

    for (int i = 0; i < FIELD_COUNT; i++) begin
      lanes_next[i] = lanes[i];
      take = 1'b0;
      if (parse && (pos >= PosW'(field_start(i)))) begin
        case (lanes[i].phase)
          PH_SPACE: begin
            if (is_space) begin
              take = 1'b0;
            end else if (is_sign) begin
              lanes_next[i].neg   = lanes[i].neg | (c == CH_MINUS);
              lanes_next[i].phase = PH_DIGITS;
            end else if (!is_digit) begin
              lanes_next[i].phase = PH_DONE;
            end else begin
              lanes_next[i].phase = PH_DIGITS;
              take = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              take = 1'b1;
            end else begin
              lanes_next[i].phase = PH_DONE;
            end
          end
          default: begin
            take = 1'b0;
          end
        endcase
        if (take) begin
          if (lanes[i].dig >= 3'(MAX_DIGITS)) begin
            lanes_next[i].over = 1'b1;
          end else begin
            lanes_next[i].dig = lanes[i].dig + 1'b1;
            lanes_next[i].mag = MAG_W'(lanes[i].mag * MAG_W'(10)) + MAG_W'(c[3:0]);
          end
        end
      end
    end

    for (int m = 0; m < 12; m++) begin
      if (!hit && (month_text_next == month_word(4'(m)))) begin
        hit  = 1'b1;
        midx = 4'(m);
      end
    end

    for (int i = 0; i < 5; i++) begin
      over_all[i] = lanes_next[i].over;
    end

    rec.zone  = (pos_next >= ZoneAt);
    rec.month = midx;
    rec.ok    = hit & ~(|over_all) & ~(rec.zone & lanes_next[F_ZONE].over);
    for (int i = 0; i < FIELD_COUNT; i++) begin
      rec.fields[i].neg = lanes_next[i].neg;
      rec.fields[i].mag = lanes_next[i].mag;
    end
  end

  // the closing character returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      pos        <= '0;
      month_text <= '0;
      ended      <= 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        lanes[i] <= '0;
      end
    end else if (accept) begin
      pos        <= pos_next;
      month_text <= month_text_next;
      ended      <= ended_next;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        lanes[i] <= lanes_next[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ctte_queue.sv
// two-entry record queue between the front and back parts
// depends on ctte_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module ctte_queue import ctte_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output rec_t      head
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  rec_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == (PtrW + 1)'(Depth));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/ctte_back.sv
// back part: turns one parsed record into epoch seconds over a fixed step sequence
// depends on ctte_pkg; holds the local offset register and the result register
`timescale 1ns / 1ps
`default_nettype none

module ctte_back import ctte_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire rec_t                       q_head,
  output logic                            q_pop,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic signed [OFFSET_W-1:0] cfg_data,
  input  wire logic                       pop,
  output logic                            empty,
  output out_item_t                       out_item
);

  back_state_t state, state_next;
  logic        out_valid, out_load;

  logic signed [OFFSET_W-1:0] local_offset;
  rec_t                       rec;
  logic signed [SVAL_W-1:0]   yadj, q4;
  logic [MAG_W-1:0]           divx;
  logic [12:0]                q0;
  logic signed [12:0]         c100, zq;
  logic signed [27:0]         days;
  logic signed [EPOCH_W-1:0]  acc;

  logic signed [SVAL_W-1:0] year_sv, yadj_in, q4_in;
  logic signed [18:0]       divx_wide;
  logic [29:0]              prod;
  logic [19:0]              rem;
  logic [12:0]              qfix;
  logic signed [SVAL_W-1:0] day_sv, hour_sv, min_sv, sec_sv, zone_sv, off_val;
  logic signed [30:0]       hour_secs;
  logic signed [23:0]       min_secs, zq_secs;
  logic signed [24:0]       off_secs;

  assign cfg_ready = 1'b1;
  assign empty     = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      local_offset <= cfg_data;
    end
  end

  // year shifted so that january and february belong to the year before
  assign year_sv   = field_sv(q_head.fields[F_YEAR]);
  assign yadj_in   = year_sv - ((q_head.month < 4'd2) ? SVAL_W'(1) : SVAL_W'(0));
  assign q4_in     = yadj_in >>> 2;
  assign divx_wide = 19'(q4_in) + 19'sd50000;

  // shared divide by 25: reciprocal estimate, then one step down if too big
  assign prod = 30'(divx) * 30'(DIV25_MUL);
  assign rem  = 20'(divx) - 20'(q0) * 20'd25;
  assign qfix = rem[19] ? (q0 - 1'b1) : q0;

  assign day_sv  = field_sv(rec.fields[F_DAY]);
  assign hour_sv = field_sv(rec.fields[F_HOUR]);
  assign min_sv  = field_sv(rec.fields[F_MIN]);
  assign sec_sv  = field_sv(rec.fields[F_SEC]);
  assign zone_sv = field_sv(rec.fields[F_ZONE]);
  assign off_val = rec.zone ? zone_sv : SVAL_W'(local_offset);

  assign hour_secs = 31'(hour_sv) * 31'sd3600;
  assign min_secs  = 24'(min_sv) * 24'sd60;
  assign off_secs  = 25'(off_val) * 25'sd60;
  assign zq_secs   = 24'(zq) * 24'sd2400;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_Y100_MUL;
        end
      end
      B_Y100_MUL: state_next = B_Y100_FIX;
      B_Y100_FIX: state_next = B_ZONE_MUL;
      B_ZONE_MUL: state_next = B_ZONE_FIX;
      B_ZONE_FIX: state_next = B_DAYS_A;
      B_DAYS_A:   state_next = B_DAYS_B;
      B_DAYS_B:   state_next = B_DAYS_C;
      B_DAYS_C:   state_next = B_SEC_MUL;
      B_SEC_MUL:  state_next = B_SEC_HOUR;
      B_SEC_HOUR: state_next = B_SEC_MIN;
      B_SEC_MIN:  state_next = B_SEC_OFF;
      B_SEC_OFF:  state_next = B_SEC_ZONE;
      B_SEC_ZONE: state_next = B_DONE;
      B_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          rec  <= q_head;
          yadj <= yadj_in;
          q4   <= q4_in;
          divx <= MAG_W'(divx_wide);
        end
      end
      B_Y100_MUL: q0 <= 13'(prod >> DIV25_SHIFT);
      B_Y100_FIX: begin
        c100 <= $signed(qfix) - 13'sd2000;
        divx <= rec.fields[F_ZONE].mag >> 2;
      end
      B_ZONE_MUL: q0 <= 13'(prod >> DIV25_SHIFT);
      B_ZONE_FIX: zq <= rec.fields[F_ZONE].neg ? -$signed(qfix) : $signed(qfix);
      B_DAYS_A:   days <= 28'(yadj) * 28'sd365 + 28'(q4);
      B_DAYS_B:   days <= days - 28'(c100) + 28'(c100 >>> 2);
      B_DAYS_C: begin
        days <= days + 28'(day_sv) + $signed({19'b0, month_doy(rec.month)})
              - 28'(EPOCH_DAY0);
      end
      B_SEC_MUL:  acc <= 43'(days) * 43'sd86400;
      B_SEC_HOUR: acc <= acc + 43'(hour_secs);
      B_SEC_MIN:  acc <= acc + 43'(min_secs) + 43'(sec_sv);
      // zone: minus 60*v plus 2400*trunc(v/100) subtracts the hhmm offset
      B_SEC_OFF:  acc <= acc - 43'(off_secs);
      B_SEC_ZONE: begin
        if (rec.zone) begin
          acc <= acc + 43'(zq_secs);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.epoch_seconds    <= rec.ok ? acc : '0;
      out_item.time_valid       <= rec.ok;
      out_item.zone_suffix_used <= rec.zone;
    end
  end

endmodule

`default_nettype wire

### tb/ctte_epoch_checker.sv
// checker for the ctime text to epoch block: watches the character, result and offset
// channels, predicts each epoch result and compares it field by field; uses ctte_pkg
`timescale 1ns / 1ps

module ctte_epoch_checker import ctte_pkg::*; #(
  parameter int TEXT_BUFFER_LENGTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  in_item_t                   in_item,
  input  logic                       empty,
  input  logic                       pop,
  input  out_item_t                  out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic signed [OFFSET_W-1:0] cfg_data,
  output int unsigned                mismatch_count,
  output int unsigned                results_due
);

  localparam logic [8*36-1:0] MONTH_NAMES = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam logic [5*FIELD_COUNT-1:0] FIELD_AT = {5'd25, 5'd20, 5'd17, 5'd14, 5'd11, 5'd8};
  localparam int LEN_CAP = 'hFFFF;

  int               text_len;
  logic [23:0]      month_seen;
  logic [MAG_W-1:0] mag [FIELD_COUNT];
  phase_t           phase [FIELD_COUNT];
  logic             neg [FIELD_COUNT];
  logic             over [FIELD_COUNT];
  int               digits [FIELD_COUNT];
  logic             nul_seen;
  logic [OFFSET_W-1:0] local_offset;
  out_item_t        epoch_due_q [$];
  int unsigned      n_mismatch = 0;

  task automatic clear_text();
    text_len   = 0;
    month_seen = '0;
    nul_seen   = 1'b0;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      mag[f]    = '0;
      phase[f]  = PH_SPACE;
      neg[f]    = 1'b0;
      over[f]   = 1'b0;
      digits[f] = 0;
    end
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // one step of atoi on field f
  task automatic feed_field(input int f, input logic [7:0] c);
    logic is_digit;
    is_digit = c >= CH_ZERO && c <= CH_NINE;
    if (phase[f] == PH_DONE) return;
    if (phase[f] == PH_SPACE) begin
      if (is_blank(c)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        if (c == CH_MINUS) neg[f] = 1'b1;
        phase[f] = PH_DIGITS;
        return;
      end
      if (!is_digit) begin
        phase[f] = PH_DONE;
        return;
      end
      phase[f] = PH_DIGITS;
    end
    if (!is_digit) begin
      phase[f] = PH_DONE;
      return;
    end
    if (digits[f] >= MAX_DIGITS) begin
      over[f] = 1'b1;
    end else begin
      digits[f]++;
      mag[f] = mag[f] * 10 + MAG_W'(c - CH_ZERO);
    end
  endtask

  function automatic longint field_num(input int f);
    longint v;
    v = longint'(mag[f]);
    return neg[f] ? -v : v;
  endfunction

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  // days from 1970-01-01 to the first of month m (0 = january) of year y
  function automatic longint days_to_month(input longint y, input longint m);
    longint mp, era, yoe, doy, doe;
    if (m < 2) y = y - 1;
    mp  = (m + 10) % 12;
    era = floor_div(y, 400);
    yoe = y - era * 400;
    doy = (153 * mp + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic close_text();
    int        month_idx;
    logic      zone_on;
    logic      valid;
    longint    secs;
    longint    zv;
    out_item_t want;
    month_idx = -1;
    for (int i = 0; i < 12; i++)
      if (month_idx < 0 && MONTH_NAMES[8*36-1-24*i -: 24] == month_seen) month_idx = i;
    zone_on = text_len >= ZONE_LENGTH;
    valid   = month_idx >= 0;
    for (int f = 0; f < F_ZONE; f++)
      if (over[f]) valid = 1'b0;
    if (zone_on && over[F_ZONE]) valid = 1'b0;
    secs = 0;
    if (valid) begin
      secs = (days_to_month(field_num(F_YEAR), longint'(month_idx)) + field_num(F_DAY) - 1)
             * 86400 + field_num(F_HOUR) * 3600 + field_num(F_MIN) * 60 + field_num(F_SEC);
      if (zone_on) begin
        zv   = field_num(F_ZONE);
        secs = secs - ((zv / 100) * 3600 + (zv % 100) * 60);
      end else begin
        secs = secs - longint'($signed(local_offset)) * 60;
      end
    end
    want.epoch_seconds    = secs[EPOCH_W-1:0];
    want.time_valid       = valid;
    want.zone_suffix_used = zone_on;
    epoch_due_q.push_back(want);
    clear_text();
  endtask

  task automatic take_char(input logic [7:0] c, input logic last);
    if (!nul_seen) begin
      if (c == CH_NUL) begin
        nul_seen = 1'b1;
      end else begin
        // bytes past the text buffer only count toward the length
        if (text_len < TEXT_BUFFER_LENGTH - 1) begin
          if (text_len >= MONTH_AT && text_len < MONTH_AT + 3)
            month_seen[8*(MONTH_AT + 2 - text_len) +: 8] = c;
          for (int f = 0; f < FIELD_COUNT; f++)
            if (text_len >= int'(FIELD_AT[5*f +: 5])) feed_field(f, c);
        end
        if (text_len < LEN_CAP) text_len++;
      end
    end
    if (last) close_text();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (epoch_due_q.size() == 0) begin
      $display("%0t: result with none due: epoch_seconds %0d time_valid %0b zone_suffix_used %0b",
               $time, $signed(got.epoch_seconds), got.time_valid, got.zone_suffix_used);
      n_mismatch++;
      return;
    end
    want = epoch_due_q.pop_front();
    if (got.epoch_seconds !== want.epoch_seconds) begin
      $display("%0t: epoch_seconds expected %0d actual %0d", $time,
               $signed(want.epoch_seconds), $signed(got.epoch_seconds));
      n_mismatch++;
    end
    if (got.time_valid !== want.time_valid) begin
      $display("%0t: time_valid expected %0b actual %0b", $time,
               want.time_valid, got.time_valid);
      n_mismatch++;
    end
    if (got.zone_suffix_used !== want.zone_suffix_used) begin
      $display("%0t: zone_suffix_used expected %0b actual %0b", $time,
               want.zone_suffix_used, got.zone_suffix_used);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_text();
      local_offset = '0;
      epoch_due_q.delete();
    end else begin
      if (pop && !empty) check_result(out_item);
      if (push && !full) take_char(in_item.text_char, in_item.last_char);
      if (cfg_valid && cfg_ready) local_offset = cfg_data;
    end
    mismatch_count <= n_mismatch;
    results_due    <= epoch_due_q.size();
  end

endmodule

### tb/ctime_text_to_epoch_top_test.sv
// top of the ctime text to epoch testbench: clock, reset, character and offset stimulus,
// result draining and the verdict; needs ctte_pkg, the block and ctte_epoch_checker
`timescale 1ns / 1ps

module ctime_text_to_epoch_top_test;
  import ctte_pkg::*;

  localparam int TEXT_LEN         = 32;
  localparam int HOLD_CYCLES      = 600;
  localparam int SETTLE_CYCLES    = 32;
  localparam int HOLD_PHASE_CHARS = 240;
  localparam int CHARS_PER_PHASE  = 30;
  localparam int RANDOM_PHASES    = 4;
  localparam int CYCLE_LIMIT      = 200000;
  localparam logic signed [OFFSET_W-1:0] OFFSET_WEST = -12'sd1440;
  localparam logic signed [OFFSET_W-1:0] OFFSET_EAST = 12'sd1440;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       push;
  logic                       full;
  in_item_t                   in_item;
  logic                       empty;
  logic                       pop;
  out_item_t                  out_item;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic signed [OFFSET_W-1:0] cfg_data;
  int unsigned                mismatch_count;
  int unsigned                results_due;
  logic                       hold_go = 1'b0;
  logic                       tx_fast = 1'b0;
  logic [7:0]                 text_q [$];
  int unsigned                cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ctime_text_to_epoch_top #(.TEXT_BUFFER_LENGTH(TEXT_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ctte_epoch_checker #(.TEXT_BUFFER_LENGTH(TEXT_LEN)) epoch_check (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= '{text_char: c, last_char: last};
    do @(posedge clk); while (full);
  endtask

  // sends the collected text, last byte marked
  task automatic send_text();
    tx_fast = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_string(input string s);
    add_text(s);
    send_text();
  endtask

  // drop the request, wait for every result and for the back stage to go quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic signed [OFFSET_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic string two_digit(input int lo, input int hi);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $sformatf("%2d", $urandom_range(0, 99));
    if (k == 1) return $sformatf("-%0d", $urandom_range(0, 9));
    if (k == 2) return $sformatf("+%0d", $urandom_range(0, 9));
    if (k < 6) return $sformatf("%02d", $urandom_range(lo, hi));
    return $sformatf("%2d", $urandom_range(lo, hi));
  endfunction

  // mostly well-formed ctime text with random content, some noise and broken text
  task automatic make_random_text();
    int          kind;
    int          n;
    int          p;
    logic [23:0] mw;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 40);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < 3; i++) text_q.push_back(8'($urandom_range('h41, 'h7A)));
    text_q.push_back(CH_SPACE);
    if ($urandom_range(0, 15) == 0) mw = 24'($urandom);
    else mw = month_word(4'($urandom_range(0, 11)));
    for (int i = 2; i >= 0; i--) text_q.push_back(mw[8*i +: 8]);
    add_text({" ", two_digit(1, 31), " ", two_digit(0, 23), ":", two_digit(0, 59), ":",
              two_digit(0, 60), " "});
    case ($urandom_range(0, 7))
      0:       add_text($sformatf("%0d", $urandom_range(0, 99999)));
      1:       add_text($sformatf("-%0d", $urandom_range(0, 99999)));
      2:       add_text($sformatf("%06d", $urandom_range(0, 999999)));
      default: add_text($sformatf("%04d", $urandom_range(1900, 2200)));
    endcase
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0:       add_text($sformatf(" %0d", $urandom_range(0, 9999)));
        1:       add_text($sformatf(" +%06d", $urandom_range(0, 999999)));
        2:       add_text($sformatf(" -%04d", $urandom_range(0, 9999)));
        default: add_text($sformatf(" %c%02d%02d", $urandom_range(0, 1) ? CH_PLUS : CH_MINUS,
                                    $urandom_range(0, 14), $urandom_range(0, 59)));
      endcase
      if ($urandom_range(0, 3) == 0) add_text($sformatf("%0d x", $urandom_range(0, 99)));
    end
    if (kind == 1) begin
      p = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       while (text_q.size() > p + 1) void'(text_q.pop_back());
        1:       text_q[p] = 8'($urandom_range(0, 255));
        default: text_q[p] = CH_NUL;
      endcase
    end
  endtask

  // strings that fall back on the local offset, plus one with a zone
  task automatic send_local_set();
    send_string("Thu Jan  1 00:00:00 1970");
    send_string("Mon Feb 29 12:30:45 2024");
    send_string("Thu Jan  1 00:00:00 1970 +010");
    send_string("Thu Jan  1 00:00:00 1970 +0100");
  endtask

  // receiver: random pauses per result, runs of no pausing, one long hold-off
  initial begin
    int   gap;
    int   taken;
    logic rx_fast;
    logic held;
    pop     = 1'b0;
    taken   = 0;
    rx_fast = 1'b0;
    held    = 1'b0;
    forever begin
      if (taken % 16 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      gap = rx_fast ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sent;
    int r;
    rst       = 1'b1;
    push      = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed texts with the offset at its reset value
    send_string("Thu Jan  1 00:00:00 1970");
    send_string("Sun Sep  9 01:46:40 2001 +0000");
    send_string("Fri Dec 31 23:59:59 9999 -1200");
    send_string("Mon Feb 29 12:30:45 2024 +0545");
    send_string("Thu jan  1 00:00:00 1970");
    send_string("Sat Aug 00 25:99:99 1969");
    send_string("Tue Mar -5 +3:-7:-9 -4713 -0030");
    send_string("Sun Dec 99 99:99:99 99999 -9999");
    send_string("Sun Jan -99999 -9:-9 -99999");
    send_string("Thu Jan  1 00:00:00 001970");
    send_string("Thu Jan  1 00:00:00 1970 +000000");
    send_string("Thu Jan  1 00:00:00 1970 +0100789");
    send_string("Thu Jan  1 00:00:00 1970 +0100 1234567890 abcdef");
    send_string("Thu Ja");
    send_string("Thu Feb 2");
    send_string("x");
    // sign with no digits, and letters where digits belong
    send_string("Wed Oct +x -: +:ab 19z9 -+12");
    // white space of every kind ahead of the fields
    add_text("Wed Apr ");
    text_q.push_back(CH_TAB);
    add_text("7 ");
    text_q.push_back(CH_VT);
    text_q.push_back(CH_FF);
    add_text("4:");
    text_q.push_back(CH_LF);
    add_text("8:");
    text_q.push_back(CH_CR);
    add_text("9  2000");
    send_text();
    // zero byte ends the text early
    add_text("Thu Jan  1 00:00:00 1970");
    text_q.push_back(CH_NUL);
    add_text(" +0100 junk");
    send_text();
    text_q.push_back(CH_NUL);
    send_text();
    // high bytes in the month
    add_text("Thu ");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    add_text("n  1 00:00:00 1970");
    text_q.push_back(8'hFF);
    send_text();

    settle();
    write_offset(OFFSET_WEST);
    send_local_set();
    settle();
    write_offset(OFFSET_EAST);
    send_local_set();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          r = int'($urandom_range(0, 2880)) - 1440;
          write_offset(OFFSET_W'(r));
        end
        1:       write_offset('0);
        2:       write_offset(OFFSET_WEST);
        default: write_offset(OFFSET_EAST);
      endcase
      // the receiver holds off once while texts keep coming
      if (ph == 0) hold_go = 1'b1;
      sent = 0;
      while (sent < ((ph == 0) ? HOLD_PHASE_CHARS : CHARS_PER_PHASE)) begin
        make_random_text();
        sent += text_q.size();
        send_text();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
